FILE: hw/rtl/srsm_pkg.sv
// Shared types, widths, codes and helpers of the striped request sector mapper.
package srsm_pkg;

    localparam int SECTOR_W     = 48;
    localparam int LEN_W        = 9;
    localparam int CHUNK_W      = 17;
    localparam int ZCOUNT_W     = 4;
    localparam int MEMBER_W     = 5;
    localparam int ZWIDTH_W     = 5;
    localparam int DEV_W        = 4;
    localparam int DIV_W        = 17;
    localparam int DIV_CNT_W    = 6;
    localparam int MOD_W        = 13;
    localparam int REQ_MAX      = 256;
    localparam int CHUNK_MIN    = 8;
    localparam int MAX_ZONES_DEF   = 8;
    localparam int MAX_MEMBERS_DEF = 16;

    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_MAP    = 2'd0,
        OP_ZONE   = 2'd1,
        OP_SLOT   = 2'd2,
        OP_OFFSET = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_CHUNK   = 2'd0,
        CFG_ZONES   = 2'd1,
        CFG_MEMBERS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                start;
        logic [SECTOR_W-1:0] dividend;
        logic [DIV_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SECTOR_W-1:0] quotient;
        logic [DIV_W-1:0]    remainder;
    } div_rsp_t;

    // Remainder of a 4-bit value by a small constant, one bit a step.
    function automatic logic [MOD_W-1:0] mod_small(input logic [3:0] value,
                                                   input logic [MOD_W-1:0] modulus);
        logic [MOD_W-1:0] r;
        r = '0;
        for (int i = 3; i >= 0; i--) begin
            r = {r[MOD_W-2:0], value[i]};
            if (r >= modulus)
                r = r - modulus;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/srsm_div.sv
// Bit-serial restoring divider shared by all divisions of the mapper.
module srsm_div
    import srsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [SECTOR_W-1:0]  quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[SECTOR_W-1]};
    assign ge    = (trial >= {1'b0, req.divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                cnt_reg  <= DIV_CNT_W'(SECTOR_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // shift one dividend bit in, subtract where it fits
                rem_reg <= ge ? DIV_W'(trial - {1'b0, req.divisor}) : trial[DIV_W-1:0];
                quo_reg <= {quo_reg[SECTOR_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: hw/rtl/striped_request_sector_mapper.sv
// Top level of the striped request sector mapper: sequencer, tables and result register.
//
// The block takes one beat at a time: a map request or a table load. A load
// answers with a single acknowledgement beat (slot loads take longer, as the
// slot address is wrapped by compare and subtract). A map request is cut at
// chunk boundaries into up to 33 pieces; for each piece the zone search reads
// the zone entries in turn, then one bit-serial divider runs three 48-step
// divisions in turn (sector by chunk, zone-relative sector by chunk, chunk
// number by zone width), the slot address is wrapped to the table depth, and a
// 17-step shift-add forms row times chunk before three adds build the device
// sector. A sector beyond the last zone ends the request with one error beat
// (tuser set, last set). The tables are undefined until loaded and need no
// clearing pass; s_axis_tready is high only while the block is idle.
module striped_request_sector_mapper
    import srsm_pkg::*;
#(
    parameter int MAX_ZONES   = MAX_ZONES_DEF,
    parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // operation[1:0], sector[49:2], length[58:50], zone_index[61:59],
    // zone_end[109:62], zone_device_start[157:110], zone_width[162:158],
    // slot_index[166:163], device_id[170:167], data_offset[218:171], zeros above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // target_device[3:0], device_sector[51:4], piece_length[60:52], zeros above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    // out_of_range[0]
    output logic                  m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CHUNK_W-1:0]    cfg_wdata
);

    localparam int SLOT_DEPTH = MAX_ZONES * MAX_MEMBERS;
    localparam int ZONE_AW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int MEM_AW     = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int ZCNT_W     = $clog2(MAX_ZONES + 1);
    localparam int IDX_W      = ZCNT_W + MEMBER_W + 1;
    localparam int MUL_CNT_W  = $clog2(CHUNK_W + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ZRD, S_ZCMP, S_DIVSEC, S_DIVREL, S_DIVQ, S_IDX, S_IDXMOD, S_SLOTWR,
        S_SRD, S_ORD, S_MUL, S_ADD1, S_ADD2, S_ADD3, S_OUT
    } state_t;

    // input fields
    logic [1:0]          in_op;
    logic [SECTOR_W-1:0] in_sector;
    logic [LEN_W-1:0]    in_length;
    logic [2:0]          in_zone_index;
    logic [SECTOR_W-1:0] in_zone_end;
    logic [SECTOR_W-1:0] in_zone_start;
    logic [ZWIDTH_W-1:0] in_zone_width;
    logic [3:0]          in_slot_index;
    logic [DEV_W-1:0]    in_device_id;
    logic [SECTOR_W-1:0] in_data_offset;

    assign in_op          = s_axis_tdata[1:0];
    assign in_sector      = s_axis_tdata[49:2];
    assign in_length      = s_axis_tdata[58:50];
    assign in_zone_index  = s_axis_tdata[61:59];
    assign in_zone_end    = s_axis_tdata[109:62];
    assign in_zone_start  = s_axis_tdata[157:110];
    assign in_zone_width  = s_axis_tdata[162:158];
    assign in_slot_index  = s_axis_tdata[166:163];
    assign in_device_id   = s_axis_tdata[170:167];
    assign in_data_offset = s_axis_tdata[218:171];

    state_t               state_reg;
    logic [CHUNK_W-1:0]   chunk_reg;
    logic [ZCOUNT_W-1:0]  zone_count_reg;
    logic [MEMBER_W-1:0]  member_count_reg;
    logic [1:0]           op_reg;
    logic [SECTOR_W-1:0]  sec_reg;
    logic [LEN_W-1:0]     remaining_reg;
    logic [LEN_W-1:0]     piece_reg;
    logic [ZCNT_W-1:0]    zidx_reg;
    logic [SECTOR_W-1:0]  prev_end_reg;
    logic [SECTOR_W-1:0]  rel_reg;
    logic [SECTOR_W-1:0]  zone_start_reg;
    logic [ZWIDTH_W-1:0]  width_reg;
    logic [CHUNK_W-1:0]   crem_reg;
    logic [SECTOR_W-1:0]  quo_reg;
    logic [ZWIDTH_W-1:0]  slot_reg;
    logic [DEV_W-1:0]     slot_dev_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SLOT_AW-1:0]   slot_addr_reg;
    logic [DEV_W-1:0]     dev_reg;
    logic [SECTOR_W-1:0]  acc_reg;
    logic [SECTOR_W-1:0]  mcand_reg;
    logic [CHUNK_W-1:0]   mult_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;
    logic                 div_go_reg;

    logic [DEV_W-1:0]     out_dev_reg;
    logic [SECTOR_W-1:0]  out_sec_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic                 out_last_reg;
    logic                 out_oor_reg;
    logic                 out_valid_reg;

    // tables
    logic [SECTOR_W-1:0]  zone_end_mem   [MAX_ZONES];
    logic [SECTOR_W-1:0]  zone_start_mem [MAX_ZONES];
    logic [ZWIDTH_W-1:0]  zone_width_mem [MAX_ZONES];
    logic [DEV_W-1:0]     slot_mem       [SLOT_DEPTH];
    logic [SECTOR_W-1:0]  offset_mem     [MAX_MEMBERS];
    logic [SECTOR_W-1:0]  end_rd_reg;
    logic [SECTOR_W-1:0]  start_rd_reg;
    logic [ZWIDTH_W-1:0]  width_rd_reg;
    logic [DEV_W-1:0]     slot_rd_reg;
    logic [SECTOR_W-1:0]  off_rd_reg;

    logic                 in_fire;
    logic                 out_fire;
    logic [CHUNK_W-1:0]   chunk_eff;
    logic [ZCNT_W-1:0]    zones_eff;
    logic [LEN_W-1:0]     len_sat;
    logic [MOD_W-1:0]     zone_mod;
    logic [MOD_W-1:0]     dev_wmod;
    logic [MOD_W-1:0]     dev_rmod;
    logic [IDX_W-1:0]     idx_sum;
    logic [CHUNK_W-1:0]   piece_full;
    logic [LEN_W-1:0]     remaining_left;
    logic                 zone_we;
    logic                 off_we;
    logic                 slot_we;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    assign chunk_eff = (chunk_reg < CHUNK_W'(CHUNK_MIN)) ? CHUNK_W'(CHUNK_MIN) : chunk_reg;
    assign zones_eff = (int'(zone_count_reg) > MAX_ZONES) ? ZCNT_W'(MAX_ZONES)
                                                          : ZCNT_W'(zone_count_reg);
    assign len_sat   = (int'(in_length) > REQ_MAX) ? LEN_W'(REQ_MAX) : in_length;

    // table indices wrap modulo the table depth
    assign zone_mod = mod_small({1'b0, in_zone_index}, MOD_W'(MAX_ZONES));
    assign dev_wmod = mod_small(in_device_id, MOD_W'(MAX_MEMBERS));
    assign dev_rmod = mod_small(slot_rd_reg, MOD_W'(MAX_MEMBERS));
    assign idx_sum  = IDX_W'(zidx_reg) * IDX_W'(member_count_reg) + IDX_W'(slot_reg);

    assign piece_full     = chunk_eff - div_rsp.remainder;
    assign remaining_left = remaining_reg - piece_reg;

    assign zone_we = in_fire && (in_op == OP_ZONE);
    assign off_we  = in_fire && (in_op == OP_OFFSET);
    assign slot_we = (state_reg == S_SLOTWR);

    // one divider, fed according to the step in progress
    always_comb
    begin
        div_req.start    = div_go_reg;
        div_req.dividend = sec_reg;
        div_req.divisor  = chunk_eff;
        case (state_reg)
            S_DIVREL:
            begin
                div_req.dividend = rel_reg;
            end
            S_DIVQ:
            begin
                div_req.dividend = quo_reg;
                div_req.divisor  = DIV_W'(width_reg);
            end
            default:
            begin
                div_req.dividend = sec_reg;
            end
        endcase
    end

    srsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (zone_we)
        begin
            zone_end_mem[zone_mod[ZONE_AW-1:0]]   <= in_zone_end;
            zone_start_mem[zone_mod[ZONE_AW-1:0]] <= in_zone_start;
            zone_width_mem[zone_mod[ZONE_AW-1:0]] <= in_zone_width;
        end
        if (slot_we)
            slot_mem[slot_addr_reg] <= slot_dev_reg;
        if (off_we)
            offset_mem[dev_wmod[MEM_AW-1:0]] <= in_data_offset;
        end_rd_reg   <= zone_end_mem[zidx_reg[ZONE_AW-1:0]];
        start_rd_reg <= zone_start_mem[zidx_reg[ZONE_AW-1:0]];
        width_rd_reg <= zone_width_mem[zidx_reg[ZONE_AW-1:0]];
        slot_rd_reg  <= slot_mem[slot_addr_reg];
        off_rd_reg   <= offset_mem[dev_rmod[MEM_AW-1:0]];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            chunk_reg        <= CHUNK_W'(128);
            zone_count_reg   <= ZCOUNT_W'(1);
            member_count_reg <= MEMBER_W'(2);
            op_reg           <= OP_MAP;
            sec_reg          <= '0;
            remaining_reg    <= '0;
            piece_reg        <= '0;
            zidx_reg         <= '0;
            prev_end_reg     <= '0;
            rel_reg          <= '0;
            zone_start_reg   <= '0;
            width_reg        <= '0;
            crem_reg         <= '0;
            quo_reg          <= '0;
            slot_reg         <= '0;
            slot_dev_reg     <= '0;
            idx_reg          <= '0;
            slot_addr_reg    <= '0;
            dev_reg          <= '0;
            acc_reg          <= '0;
            mcand_reg        <= '0;
            mult_reg         <= '0;
            mul_cnt_reg      <= '0;
            div_go_reg       <= 1'b0;
            out_dev_reg      <= '0;
            out_sec_reg      <= '0;
            out_len_reg      <= '0;
            out_last_reg     <= 1'b0;
            out_oor_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHUNK:   chunk_reg        <= cfg_wdata;
                    CFG_ZONES:   zone_count_reg   <= cfg_wdata[ZCOUNT_W-1:0];
                    CFG_MEMBERS: member_count_reg <= cfg_wdata[MEMBER_W-1:0];
                    default:     ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg <= in_op;
                        // acknowledgement beat unless a map with work
                        out_dev_reg  <= '0;
                        out_sec_reg  <= '0;
                        out_len_reg  <= '0;
                        out_last_reg <= 1'b1;
                        out_oor_reg  <= 1'b0;
                        case (in_op)
                            OP_MAP:
                            begin
                                if (len_sat == '0)
                                begin
                                    out_valid_reg <= 1'b1;
                                    state_reg     <= S_OUT;
                                end
                                else
                                begin
                                    sec_reg       <= in_sector;
                                    remaining_reg <= len_sat;
                                    zidx_reg      <= '0;
                                    state_reg     <= S_ZRD;
                                end
                            end
                            OP_SLOT:
                            begin
                                zidx_reg     <= ZCNT_W'(zone_mod[ZONE_AW-1:0]);
                                slot_reg     <= ZWIDTH_W'(in_slot_index);
                                slot_dev_reg <= in_device_id;
                                state_reg    <= S_IDX;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_OUT;
                            end
                        endcase
                    end
                end
                S_ZRD:
                begin
                    if (zidx_reg == zones_eff)
                    begin
                        // past the last zone: end the request with an error beat
                        out_dev_reg   <= '0;
                        out_sec_reg   <= '0;
                        out_len_reg   <= '0;
                        out_last_reg  <= 1'b1;
                        out_oor_reg   <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                        state_reg <= S_ZCMP;
                end
                S_ZCMP:
                begin
                    if (sec_reg < end_rd_reg)
                    begin
                        rel_reg        <= (zidx_reg == '0) ? sec_reg : sec_reg - prev_end_reg;
                        zone_start_reg <= start_rd_reg;
                        width_reg      <= (width_rd_reg == '0) ? ZWIDTH_W'(1) : width_rd_reg;
                        div_go_reg     <= 1'b1;
                        state_reg      <= S_DIVSEC;
                    end
                    else
                    begin
                        prev_end_reg <= end_rd_reg;
                        zidx_reg     <= zidx_reg + 1'b1;
                        state_reg    <= S_ZRD;
                    end
                end
                S_DIVSEC:
                begin
                    if (div_rsp.done)
                    begin
                        // piece runs to the next chunk boundary or the request end
                        piece_reg  <= (piece_full > CHUNK_W'(remaining_reg))
                                      ? remaining_reg : piece_full[LEN_W-1:0];
                        div_go_reg <= 1'b1;
                        state_reg  <= S_DIVREL;
                    end
                end
                S_DIVREL:
                begin
                    if (div_rsp.done)
                    begin
                        crem_reg   <= div_rsp.remainder;
                        quo_reg    <= div_rsp.quotient;
                        div_go_reg <= 1'b1;
                        state_reg  <= S_DIVQ;
                    end
                end
                S_DIVQ:
                begin
                    if (div_rsp.done)
                    begin
                        quo_reg   <= div_rsp.quotient;
                        slot_reg  <= div_rsp.remainder[ZWIDTH_W-1:0];
                        state_reg <= S_IDX;
                    end
                end
                S_IDX:
                begin
                    idx_reg   <= idx_sum;
                    state_reg <= S_IDXMOD;
                end
                S_IDXMOD:
                begin
                    // wrap the slot address into the table, one subtract a cycle
                    if (idx_reg >= IDX_W'(SLOT_DEPTH))
                        idx_reg <= idx_reg - IDX_W'(SLOT_DEPTH);
                    else
                    begin
                        slot_addr_reg <= idx_reg[SLOT_AW-1:0];
                        state_reg     <= (op_reg == OP_SLOT) ? S_SLOTWR : S_SRD;
                    end
                end
                S_SLOTWR:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_SRD:
                begin
                    state_reg <= S_ORD;
                end
                S_ORD:
                begin
                    dev_reg     <= slot_rd_reg;
                    acc_reg     <= '0;
                    mcand_reg   <= quo_reg;
                    mult_reg    <= chunk_eff;
                    mul_cnt_reg <= MUL_CNT_W'(CHUNK_W);
                    state_reg   <= S_MUL;
                end
                S_MUL:
                begin
                    // row times chunk, one multiplier bit a cycle
                    if (mult_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg   <= {mcand_reg[SECTOR_W-2:0], 1'b0};
                    mult_reg    <= {1'b0, mult_reg[CHUNK_W-1:1]};
                    mul_cnt_reg <= mul_cnt_reg - 1'b1;
                    if (mul_cnt_reg == MUL_CNT_W'(1))
                        state_reg <= S_ADD1;
                end
                S_ADD1:
                begin
                    acc_reg   <= acc_reg + SECTOR_W'(crem_reg);
                    state_reg <= S_ADD2;
                end
                S_ADD2:
                begin
                    acc_reg   <= acc_reg + zone_start_reg;
                    state_reg <= S_ADD3;
                end
                S_ADD3:
                begin
                    out_dev_reg   <= dev_reg;
                    out_sec_reg   <= acc_reg + off_rd_reg;
                    out_len_reg   <= piece_reg;
                    out_last_reg  <= (remaining_left == '0);
                    out_oor_reg   <= 1'b0;
                    out_valid_reg <= 1'b1;
                    remaining_reg <= remaining_left;
                    sec_reg       <= sec_reg + SECTOR_W'(piece_reg);
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        zidx_reg      <= '0;
                        state_reg     <= out_last_reg ? S_IDLE : S_ZRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_len_reg, out_sec_reg, out_dev_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_oor_reg;

endmodule

FILE: hw/rtl/srsm_check.sv
// Port-level checker of the striped request sector mapper and its bind.
module srsm_check
    import srsm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tuser
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // never take a new beat while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // drop ready after accepting a beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready held after accept");

    // an error beat ends the request and carries no sectors
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[60:52] == '0))
        else $error("error beat not final or not empty");

endmodule

bind striped_request_sector_mapper srsm_check u_srsm_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_striped_request_sector_mapper.sv
// Self-checking testbench for the striped request sector mapper.
`timescale 1ns / 100ps

module tb_striped_request_sector_mapper;
    import srsm_pkg::*;

    localparam int ZONE_DEPTH = 8;
    localparam int SLOT_DEPTH = 128;
    localparam int DEV_DEPTH  = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;
    // Loaded part of the tables: zones 0..3 with a stride of 8 slots, devices 0..7.
    localparam int ZONES_LOADED = 4;
    localparam int MEMBERS_FILL = 8;
    localparam int WIDTH_MAX    = 8;
    localparam int DEVS_USED    = 8;
    localparam int PHASES       = 5;

    // Register settings of the random phases; slot addresses stay in the loaded part.
    localparam logic [16:0] PH_CHUNK   [PHASES] = '{17'd0, 17'h1_FFFF, 17'd100, 17'd24,
                                                    17'h1_0000};
    localparam logic [3:0]  PH_ZONES   [PHASES] = '{4'd4, 4'd15, 4'd1, 4'd4, 4'd0};
    localparam logic [4:0]  PH_MEMBERS [PHASES] = '{5'd8, 5'd0, 5'd31, 5'd5, 5'd2};
    localparam int          PH_LAYOUT  [PHASES] = '{4, 8, 4, 4, 0};

    typedef struct {
        op_t         op;
        logic [47:0] sector;
        logic [8:0]  length;
        logic [2:0]  zone_index;
        logic [47:0] zone_end;
        logic [47:0] zone_start;
        logic [4:0]  zone_width;
        logic [3:0]  slot_index;
        logic [3:0]  device_id;
        logic [47:0] data_offset;
    } request_t;

    typedef struct {
        logic [3:0]  device;
        logic [47:0] dev_sector;
        logic [8:0]  piece_len;
        logic        last;
        logic        out_of_range;
    } piece_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CHUNK_W-1:0]    cfg_wdata;

    // Mirror of the block's registers and tables.
    logic [16:0] chunk_reg;
    logic [3:0]  zones_reg;
    logic [4:0]  members_reg;
    logic [47:0] zone_end_mem   [ZONE_DEPTH];
    logic [47:0] zone_start_mem [ZONE_DEPTH];
    logic [4:0]  zone_width_mem [ZONE_DEPTH];
    logic [3:0]  slot_mem       [SLOT_DEPTH];
    logic [47:0] dev_offset_mem [DEV_DEPTH];

    request_t pending_reqs[$];
    piece_t   expected_pieces[$];
    request_t held_req;
    logic     no_gaps;
    logic     failed = 1'b0;
    int       quiet_cycles = 0;
    // Array size of the current zone layout, used to aim sectors.
    longint unsigned layout_end;

    striped_request_sector_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [IN_DATA_W-1:0] pack_request(request_t r);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[1:0]     = r.op;
        d[49:2]    = r.sector;
        d[58:50]   = r.length;
        d[61:59]   = r.zone_index;
        d[109:62]  = r.zone_end;
        d[157:110] = r.zone_start;
        d[162:158] = r.zone_width;
        d[166:163] = r.slot_index;
        d[170:167] = r.device_id;
        d[218:171] = r.data_offset;
        return d;
    endfunction

    function automatic void push_piece(logic [3:0] dev, logic [47:0] dsec,
                                       logic [8:0] len, logic last, logic oor);
        piece_t p;
        p.device       = dev;
        p.dev_sector   = dsec;
        p.piece_len    = len;
        p.last         = last;
        p.out_of_range = oor;
        expected_pieces.push_back(p);
    endfunction

    // Apply a load to the mirror tables or split a map request into pieces.
    function automatic void split_request(request_t r);
        longint unsigned chunk, zones, sec, left, piece, rel, width, row, slot, dsec;
        int unsigned     hit, slot_addr;
        logic [3:0]      dev;
        case (r.op)
            OP_ZONE:
            begin
                zone_end_mem[r.zone_index]   = r.zone_end;
                zone_start_mem[r.zone_index] = r.zone_start;
                zone_width_mem[r.zone_index] = r.zone_width;
                push_piece('0, '0, '0, 1'b1, 1'b0);
            end
            OP_SLOT:
            begin
                slot_addr = (r.zone_index * members_reg + r.slot_index) % SLOT_DEPTH;
                slot_mem[slot_addr] = r.device_id;
                push_piece('0, '0, '0, 1'b1, 1'b0);
            end
            OP_OFFSET:
            begin
                dev_offset_mem[r.device_id] = r.data_offset;
                push_piece('0, '0, '0, 1'b1, 1'b0);
            end
            default:
            begin
                chunk = (chunk_reg < 8) ? 8 : chunk_reg;
                zones = (zones_reg > ZONE_DEPTH) ? ZONE_DEPTH : zones_reg;
                sec   = r.sector;
                left  = (r.length > REQ_MAX) ? REQ_MAX : r.length;
                if (left == 0)
                    push_piece('0, '0, '0, 1'b1, 1'b0);
                while (left > 0)
                begin
                    piece = chunk - (sec % chunk);
                    if (piece > left)
                        piece = left;
                    hit = ZONE_DEPTH;
                    rel = sec;
                    for (int z = 0; z < zones; z++)
                    begin
                        if (hit == ZONE_DEPTH && sec < zone_end_mem[z])
                        begin
                            hit = z;
                            if (z > 0)
                                rel = (sec - zone_end_mem[z-1]) & 48'hFFFF_FFFF_FFFF;
                        end
                    end
                    if (hit == ZONE_DEPTH)
                    begin
                        // Beyond the last zone: one error beat ends the request.
                        push_piece('0, '0, '0, 1'b1, 1'b1);
                        return;
                    end
                    width = (zone_width_mem[hit] == 0) ? 1 : zone_width_mem[hit];
                    slot  = (rel / chunk) % width;
                    row   = rel / (chunk * width);
                    dev   = slot_mem[(hit * members_reg + slot) % SLOT_DEPTH];
                    dsec  = row * chunk + rel % chunk + zone_start_mem[hit]
                            + dev_offset_mem[dev];
                    left  = left - piece;
                    push_piece(dev, dsec[47:0], piece[8:0], left == 0, 1'b0);
                    sec = (sec + piece) & 48'hFFFF_FFFF_FFFF;
                end
            end
        endcase
    endfunction

    // Driver: predict on each accepted beat, then present the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                split_request(held_req);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() > 0 && (no_gaps || $urandom_range(99) >= 9))
                begin
                    held_req      <= pending_reqs[0];
                    s_axis_tdata  <= pack_request(pending_reqs[0]);
                    s_axis_tvalid <= 1'b1;
                    void'(pending_reqs.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and field-by-field compare.
    always @(posedge clk or negedge rst_n)
    begin
        piece_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= no_gaps || ($urandom_range(99) >= 9);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pieces.size() == 0)
                begin
                    $display("%0t: unexpected beat: got dev %0d sec %h len %0d last %b oor %b",
                             $time, m_axis_tdata[3:0], m_axis_tdata[51:4],
                             m_axis_tdata[60:52], m_axis_tlast, m_axis_tuser);
                    failed <= 1'b1;
                end
                else
                begin
                    want = expected_pieces.pop_front();
                    if (m_axis_tdata[3:0] !== want.device
                        || m_axis_tdata[51:4] !== want.dev_sector
                        || m_axis_tdata[60:52] !== want.piece_len
                        || m_axis_tdata[63:61] !== 3'b000
                        || m_axis_tlast !== want.last
                        || m_axis_tuser !== want.out_of_range)
                    begin
                        $display("%0t: mismatch: expected dev %0d sec %h len %0d last %b oor %b",
                                 $time, want.device, want.dev_sector, want.piece_len,
                                 want.last, want.out_of_range);
                        $display("%0t:           actual dev %0d sec %h len %0d last %b oor %b",
                                 $time, m_axis_tdata[3:0], m_axis_tdata[51:4],
                                 m_axis_tdata[60:52], m_axis_tlast, m_axis_tuser);
                        failed <= 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic request_t blank_request(op_t op);
        request_t r;
        r.op          = op;
        r.sector      = 48'({$urandom, $urandom});
        r.length      = 9'($urandom);
        r.zone_index  = 3'($urandom);
        r.zone_end    = 48'({$urandom, $urandom});
        r.zone_start  = 48'({$urandom, $urandom});
        r.zone_width  = 5'($urandom);
        r.slot_index  = 4'($urandom);
        r.device_id   = 4'($urandom);
        r.data_offset = 48'({$urandom, $urandom});
        return r;
    endfunction

    function automatic void queue_map(logic [47:0] sector, logic [8:0] length);
        request_t r;
        r        = blank_request(OP_MAP);
        r.sector = sector;
        r.length = length;
        pending_reqs.push_back(r);
    endfunction

    // Lay out zones 0..count-1 back to back with random spans and widths.
    function automatic void queue_layout(int count, bit top_open);
        request_t        r;
        longint unsigned chunk, span;
        chunk = (chunk_reg < 8) ? 8 : chunk_reg;
        layout_end = 0;
        for (int z = 0; z < count; z++)
        begin
            r = blank_request(OP_ZONE);
            r.zone_index = 3'(z);
            r.zone_width = ($urandom_range(9) == 0) ? 5'd0 : 5'($urandom_range(WIDTH_MAX, 1));
            span = chunk * r.zone_width * $urandom_range(12, 1) + $urandom_range(chunk);
            layout_end = layout_end + span;
            r.zone_end = (top_open && z == count - 1) ? 48'hFFFF_FFFF_FFFF : 48'(layout_end);
            r.zone_start = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) :
                           48'($urandom_range(1 << 20));
            pending_reqs.push_back(r);
        end
    endfunction

    // Random table load that keeps every later lookup inside the loaded entries.
    function automatic void queue_random_load();
        request_t r;
        r = blank_request(op_t'($urandom_range(3, 1)));
        r.zone_index = 3'($urandom_range(ZONES_LOADED - 1));
        r.zone_width = 5'($urandom_range(WIDTH_MAX));
        if (r.op == OP_SLOT)
            r.device_id = 4'($urandom_range(DEVS_USED - 1));
        pending_reqs.push_back(r);
    endfunction

    // Random map request aimed mostly inside the layout, with some misses.
    function automatic void queue_random_map();
        logic [47:0] sec;
        logic [8:0]  len;
        case ($urandom_range(9))
            0:       sec = 48'(layout_end + $urandom_range(500));
            1:       sec = 48'({$urandom, $urandom});
            2:       sec = 48'(48'hFFFF_FFFF_FFFF - $urandom_range(300));
            default: sec = 48'({$urandom, $urandom} % (layout_end + 1));
        endcase
        case ($urandom_range(19))
            0:       len = 9'd0;
            1:       len = 9'($urandom_range(511, 257));
            2, 3:    len = 9'($urandom_range(256, 100));
            default: len = 9'($urandom_range(40, 1));
        endcase
        queue_map(sec, len);
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_pieces.size() > 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CHUNK_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_CHUNK:   chunk_reg   = value;
            CFG_ZONES:   zones_reg   = value[3:0];
            CFG_MEMBERS: members_reg = value[4:0];
            default:     ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        request_t r;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_CHUNK;
        cfg_wdata   = '0;
        no_gaps     = 1'b0;
        chunk_reg   = 17'd128;
        zones_reg   = 4'd1;
        members_reg = 5'd2;
        layout_end  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the slots of the first zones with a stride of 8 and the offsets
        // of the devices those slots name.
        write_reg(CFG_MEMBERS, 17'(MEMBERS_FILL));
        for (int z = 0; z < ZONES_LOADED; z++)
            for (int s = 0; s < MEMBERS_FILL; s++)
            begin
                r = blank_request(OP_SLOT);
                r.zone_index = 3'(z);
                r.slot_index = 4'(s);
                r.device_id  = 4'($urandom_range(DEVS_USED - 1));
                pending_reqs.push_back(r);
            end
        for (int d = 0; d < DEVS_USED; d++)
        begin
            r = blank_request(OP_OFFSET);
            r.device_id = 4'(d);
            if (d == DEVS_USED - 1)
                r.data_offset = 48'hFFFF_FFFF_FFFF;
            pending_reqs.push_back(r);
        end
        queue_layout(ZONES_LOADED, 1'b0);
        wait_idle();
        write_reg(CFG_MEMBERS, 17'd2);

        // Directed: extremes of lengths and sectors with the reset chunk.
        queue_map(48'd0, 9'd1);
        queue_map(48'd5, 9'd256);
        queue_map(48'd3, 9'd0);
        queue_map(48'd130, 9'd511);
        queue_map(48'd127, 9'd2);
        queue_map(layout_end[47:0], 9'd4);
        queue_map(48'hFFFF_FFFF_FFFF, 9'd256);
        queue_map(48'h8000_0000_0000, 9'd300);
        wait_idle();
        write_reg(CFG_CHUNK, 17'd8);
        write_reg(CFG_ZONES, 17'(ZONES_LOADED));
        queue_layout(ZONES_LOADED, 1'b1);
        // Unaligned 256-sector request at the smallest chunk: 33 pieces.
        queue_map(48'd3, 9'd256);
        queue_map(48'hFFFF_FFFF_FFFC, 9'd20);
        queue_map(48'd0, 9'd256);
        wait_idle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_CHUNK, PH_CHUNK[p]);
            write_reg(CFG_ZONES, {13'd0, PH_ZONES[p]});
            write_reg(CFG_MEMBERS, {12'd0, PH_MEMBERS[p]});
            no_gaps = (p == 2);
            queue_layout(PH_LAYOUT[p], p == 3);
            for (int i = 0; i < 6; i++)
            begin
                if ($urandom_range(9) < 7)
                    queue_random_map();
                else
                    queue_random_load();
            end
            wait_idle();
        end
        no_gaps = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && expected_pieces.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
